// ===== hw/rtl/pwmf_pkg.sv =====
package pwmf_pkg;

    // Frame limits and the counter widths that follow from them.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int EW_W       = COL_W + 1;
    localparam int EH_W       = ROW_W + 1;

    // Configuration registers.
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam logic [WREG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd480;

    // Pixel layout.
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int RGB_W  = CH_W * NUM_CH;

    // Plus-shaped window: up to five values, only the three lowest matter.
    localparam int WIN_N = 5;
    localparam int MED_N = 3;
    localparam int CNT_W = 3;

    // Compare-exchange pairs of a nine-comparator sorting network for five keys.
    localparam int NUM_CAS = 9;
    localparam int unsigned CAS_LO [NUM_CAS] = '{0, 3, 2, 2, 1, 0, 0, 1, 1};
    localparam int unsigned CAS_HI [NUM_CAS] = '{1, 4, 4, 3, 4, 3, 2, 3, 2};

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } t_action;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [RGB_W-1:0] t_rgb;
    typedef logic [CH_W:0]    t_key;

    // A missing neighbor sorts above every real sample.
    localparam t_key KEY_NONE = {1'b1, {CH_W{1'b0}}};

    typedef struct packed {
        logic sel;
        t_rgb rgb;
    } t_mid;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_col;
        logic             m_we;
        t_mid             m_wdata;
        logic             u_we;
        logic [COL_W-1:0] u_waddr;
        t_rgb             u_wdata;
    } t_store_req;

endpackage

// ===== hw/rtl/pwmf_in_if.sv =====
interface pwmf_in_if;
    import pwmf_pkg::*;

    logic  valid;
    logic  ready;
    logic  action;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;
    logic  selected;

    modport source (
        output valid, action, red_in, green_in, blue_in, selected,
        input  ready
    );

    modport sink (
        input  valid, action, red_in, green_in, blue_in, selected,
        output ready
    );
endinterface

// ===== hw/rtl/pwmf_out_if.sv =====
interface pwmf_out_if;
    import pwmf_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    logic  frame_end;

    modport source (
        output valid, red_out, green_out, blue_out, frame_end,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, frame_end,
        output ready
    );
endinterface

// ===== hw/rtl/pwmf_line_store.sv =====
module pwmf_line_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwmf_pkg::t_store_req i_req,
    output pwmf_pkg::t_mid       o_centre,
    output pwmf_pkg::t_rgb       o_right,
    output pwmf_pkg::t_rgb       o_up
);
    import pwmf_pkg::*;

    t_mid             r_mid_mem [MAX_WIDTH];
    t_rgb             r_up_mem  [MAX_WIDTH];
    t_mid             r_centre_q;
    t_mid             r_right_q;
    t_rgb             r_up_q;
    logic             r_fwd_v;
    t_rgb             r_fwd_d;
    logic [COL_W-1:0] w_right_col;

    assign w_right_col = i_req.rd_col + 1'b1;

    // Output row store: read before write, so the centre read sees the old entry.
    always_ff @(posedge i_clk) begin
        if (i_req.m_we) begin
            r_mid_mem[i_req.rd_col] <= i_req.m_wdata;
        end
        if (i_req.rd_en) begin
            r_centre_q <= r_mid_mem[i_req.rd_col];
            r_right_q  <= r_mid_mem[w_right_col];
        end
    end

    // Row-above store.
    always_ff @(posedge i_clk) begin
        if (i_req.u_we) begin
            r_up_mem[i_req.u_waddr] <= i_req.u_wdata;
        end
        if (i_req.rd_en) begin
            r_up_q <= r_up_mem[i_req.rd_col];
        end
    end

    // A write to the entry being read in the same cycle is bypassed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (i_req.rd_en) begin
            r_fwd_v <= i_req.u_we && (i_req.u_waddr == i_req.rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_fwd_d <= i_req.u_wdata;
        end
    end

    assign o_centre = r_centre_q;
    assign o_right  = r_right_q.rgb;
    assign o_up     = r_fwd_v ? r_fwd_d : r_up_q;

endmodule

// ===== hw/rtl/pwmf_sort5.sv =====
module pwmf_sort5 (
    input  pwmf_pkg::t_key  i_key [pwmf_pkg::WIN_N],
    output pwmf_pkg::t_chan o_low [pwmf_pkg::MED_N]
);
    import pwmf_pkg::*;

    t_key w_k [WIN_N];
    t_key w_t;

    always_comb begin
        w_k = i_key;
        w_t = '0;
        for (int i = 0; i < NUM_CAS; i++) begin
            if (w_k[CAS_LO[i]] > w_k[CAS_HI[i]]) begin
                w_t            = w_k[CAS_LO[i]];
                w_k[CAS_LO[i]] = w_k[CAS_HI[i]];
                w_k[CAS_HI[i]] = w_t;
            end
        end
    end

    for (genvar g = 0; g < MED_N; g++) begin : g_low
        assign o_low[g] = w_k[g][CH_W-1:0];
    end

endmodule

// ===== hw/rtl/plus_window_rgb_median_filter.sv =====
// Channel      Dir  Handshake          Payload
// i_pix        in   valid / ready      action, red_in, green_in, blue_in, selected
// o_res        out  valid / ready      red_out, green_out, blue_out, frame_end
// cfg write    in   i_cfg_we           i_cfg_idx, i_cfg_wdata (image_width, image_height)
//
// One item is taken per clock unless a stall holds i_pix. A pixel in row y emits the pixel
// of row y-1 at the same column, and a result passes stage 1 and stage 2 on its way to the
// output register. The rate is set by the two line stores: the output row store serves two
// reads and one write per cycle, the row-above store one read and one write.
// Reset (synchronous, active low) clears the counters, the pipeline valids and loads the
// default frame size; the line stores have no clearing pass.
// A stall at o_res backs up through the output register and the two median stages to i_pix.

module plus_window_rgb_median_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pwmf_in_if.sink                         i_pix,
    pwmf_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  pwmf_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [pwmf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pwmf_pkg::*;

    // Configuration and position counters.
    logic [WREG_W-1:0] r_img_w;
    logic [HREG_W-1:0] r_img_h;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_drain_col;
    logic              r_draining;
    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [COL_W-1:0]  n_drain_col;
    logic              n_draining;

    // Item decode.
    logic [EW_W-1:0]   w_eff_w;
    logic [EH_W-1:0]   w_eff_h;
    logic              w_is_drain;
    logic [COL_W-1:0]  w_x;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_pix_eff;
    logic              w_drn_eff;
    logic              w_eff;
    logic              w_emit;
    logic              w_have_up;
    logic              w_accept;
    t_rgb              w_pix_rgb;

    // Handshake through the pipeline.
    logic              w_o_free;
    logic              w_s2_free;
    logic              w_s1_free;
    logic              w_s1_adv;

    // Stage 1: line store data arrives, keys are sorted.
    logic              r_s1_v;
    logic              r_s1_emit;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_right;
    logic              r_s1_left;
    logic              r_s1_up;
    logic              r_s1_down;
    t_rgb              r_s1_down_rgb;
    logic              r_s1_fend;
    t_rgb              r_left_rgb;

    t_store_req        w_req;
    t_mid              w_centre;
    t_rgb              w_right;
    t_rgb              w_up;
    t_key              w_key [NUM_CH][WIN_N];
    t_chan             w_low [NUM_CH][MED_N];
    logic [CNT_W-1:0]  w_n;

    // Stage 2: median selection.
    logic              r_s2_v;
    t_chan             r_s2_low [NUM_CH][MED_N];
    logic [CNT_W-1:0]  r_s2_n;
    logic              r_s2_sel;
    t_rgb              r_s2_rgb;
    logic              r_s2_fend;
    t_rgb              w_med_rgb;

    // Output register.
    logic              r_o_v;
    t_rgb              r_o_rgb;
    logic              r_o_fend;

    function automatic t_chan chan_of(input t_rgb v, input int c);
        return v[RGB_W - CH_W * (c + 1) +: CH_W];
    endfunction

    // Odd count: middle value. Even count: truncated mean of the two middle values.
    function automatic t_chan pick(input t_chan s0, input t_chan s1, input t_chan s2,
                                   input logic [CNT_W-1:0] n);
        logic [CH_W:0] sum01;
        logic [CH_W:0] sum12;
        t_chan         res;
        sum01 = {1'b0, s0} + {1'b0, s1};
        sum12 = {1'b0, s1} + {1'b0, s2};
        unique case (n)
            3'd1:    res = s0;
            3'd2:    res = sum01[CH_W:1];
            3'd3:    res = s1;
            3'd4:    res = sum12[CH_W:1];
            3'd5:    res = s2;
            default: res = s0;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RST;
            r_img_h <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_wdata[WREG_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_wdata[HREG_W-1:0];
            endcase
        end
    end

    // Out-of-range sizes are clamped to 1..maximum.
    assign w_eff_w = (r_img_w == '0) ? EW_W'(1) :
                     (r_img_w > WREG_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : EW_W'(r_img_w);
    assign w_eff_h = (r_img_h == '0) ? EH_W'(1) :
                     (r_img_h > HREG_W'(MAX_HEIGHT)) ? EH_W'(MAX_HEIGHT) : EH_W'(r_img_h);

    // ---------------------------------------------------------------------------------
    // Item decode. A pixel while the last row drains, or a drain item with nothing
    // pending, is taken and dropped.
    // ---------------------------------------------------------------------------------
    assign w_is_drain = (i_pix.action == ACT_DRAIN);
    assign w_x        = w_is_drain ? r_drain_col : r_in_col;
    assign w_last_col = ({1'b0, w_x} + EW_W'(1)) >= w_eff_w;
    assign w_last_row = ({1'b0, r_in_row} + EH_W'(1)) >= w_eff_h;
    assign w_pix_eff  = !w_is_drain && !r_draining;
    assign w_drn_eff  = w_is_drain && r_draining;
    assign w_eff      = w_pix_eff || w_drn_eff;
    assign w_emit     = w_drn_eff || (w_pix_eff && (r_in_row != '0));
    assign w_have_up  = w_drn_eff ? (w_eff_h >= EH_W'(2)) : (r_in_row >= ROW_W'(2));
    assign w_pix_rgb  = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    // Each stage moves on when the one after it is empty or moving too.
    assign w_o_free  = !r_o_v || o_res.ready;
    assign w_s2_free = !r_s2_v || w_o_free;
    assign w_s1_adv  = r_s1_v && (!r_s1_emit || w_s2_free);
    assign w_s1_free = !r_s1_v || w_s1_adv;

    assign i_pix.ready = w_s1_free;
    assign w_accept    = i_pix.valid && w_s1_free;

    // ---------------------------------------------------------------------------------
    // Position counters
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_drain_col = r_drain_col;
        n_draining  = r_draining;
        if (w_accept) begin
            if (w_pix_eff) begin
                if (w_last_col) begin
                    n_in_col = '0;
                    if (w_last_row) begin
                        // The frame is in; the last row now waits for drain items.
                        n_in_row    = '0;
                        n_draining  = 1'b1;
                        n_drain_col = '0;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
            end else if (w_drn_eff) begin
                if (w_last_col) begin
                    n_draining  = 1'b0;
                    n_drain_col = '0;
                end else begin
                    n_drain_col = r_drain_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
        end else begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_drain_col <= n_drain_col;
            r_draining  <= n_draining;
        end
    end

    // ---------------------------------------------------------------------------------
    // Line stores. The output row entry is read and replaced by the incoming pixel in the
    // same cycle; the row-above entry is rewritten with the centre as stage 1 retires.
    // ---------------------------------------------------------------------------------
    always_comb begin
        w_req.rd_en   = w_accept && w_eff;
        w_req.rd_col  = w_x;
        w_req.m_we    = w_accept && w_pix_eff;
        w_req.m_wdata = '{sel: i_pix.selected, rgb: w_pix_rgb};
        w_req.u_we    = w_s1_adv;
        w_req.u_waddr = r_s1_col;
        w_req.u_wdata = w_centre.rgb;
    end

    pwmf_line_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_centre (w_centre),
        .o_right  (w_right),
        .o_up     (w_up)
    );

    // ---------------------------------------------------------------------------------
    // Stage 1
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_v <= w_accept && w_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_eff) begin
            r_s1_emit     <= w_emit;
            r_s1_col      <= w_x;
            r_s1_right    <= !w_last_col;
            r_s1_left     <= (w_x != '0);
            r_s1_up       <= w_have_up;
            r_s1_down     <= w_pix_eff;
            r_s1_down_rgb <= w_pix_rgb;
            r_s1_fend     <= w_drn_eff && w_last_col;
        end
        // The left neighbor is the centre of the step just before, already in the
        // row-above store; a copy is kept here so no second read is needed.
        if (w_s1_adv) begin
            r_left_rgb <= w_centre.rgb;
        end
    end

    // Missing neighbors sort to the top, so the present values come first.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_key[c][0] = {1'b0, chan_of(w_centre.rgb, c)};
            w_key[c][1] = r_s1_right ? {1'b0, chan_of(w_right, c)}       : KEY_NONE;
            w_key[c][2] = r_s1_left  ? {1'b0, chan_of(r_left_rgb, c)}    : KEY_NONE;
            w_key[c][3] = r_s1_down  ? {1'b0, chan_of(r_s1_down_rgb, c)} : KEY_NONE;
            w_key[c][4] = r_s1_up    ? {1'b0, chan_of(w_up, c)}          : KEY_NONE;
        end
    end

    assign w_n = CNT_W'(1) + CNT_W'(r_s1_right) + CNT_W'(r_s1_left)
               + CNT_W'(r_s1_down) + CNT_W'(r_s1_up);

    for (genvar c = 0; c < NUM_CH; c++) begin : g_sort
        pwmf_sort5 u_sort (
            .i_key (w_key[c]),
            .o_low (w_low[c])
        );
    end

    // ---------------------------------------------------------------------------------
    // Stage 2
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_v <= w_s1_adv && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free && w_s1_adv && r_s1_emit) begin
            r_s2_low  <= w_low;
            r_s2_n    <= w_n;
            r_s2_sel  <= w_centre.sel;
            r_s2_rgb  <= w_centre.rgb;
            r_s2_fend <= r_s1_fend;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_med_rgb[RGB_W - CH_W * (c + 1) +: CH_W] =
                pick(r_s2_low[c][0], r_s2_low[c][1], r_s2_low[c][2], r_s2_n);
        end
    end

    // ---------------------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_o_free) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_free && r_s2_v) begin
            r_o_rgb  <= r_s2_sel ? w_med_rgb : r_s2_rgb;
            r_o_fend <= r_s2_fend;
        end
    end

    assign o_res.valid     = r_o_v;
    assign o_res.red_out   = r_o_rgb[RGB_W-1 -: CH_W];
    assign o_res.green_out = r_o_rgb[RGB_W-CH_W-1 -: CH_W];
    assign o_res.blue_out  = r_o_rgb[CH_W-1:0];
    assign o_res.frame_end = r_o_fend;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------

    // While the last row drains, the input position has already wrapped to the origin.
    a_drain_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_in_col == '0) && (r_in_row == '0))
        else $error("input position not at origin while draining");

    // The drain position rests at zero outside a drain.
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_draining |-> (r_drain_col == '0))
        else $error("drain column moved outside a drain");

    // A stage-1 item that cannot retire keeps its place and its row-above address.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !w_s1_adv |=> r_s1_v && $stable(r_s1_col))
        else $error("stage 1 item lost while stalled");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pwmf_pkg::*;

    // One output pixel as it leaves the block.
    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  frame_end;
    } t_pixel_res;

    // One row of the directed script. Rows with a typed result carry the pixel the
    // filter must produce for that item; the other rows are checked by prediction.
    typedef struct packed {
        t_action    act;
        t_rgb       rgb;
        logic       sel;
        bit         typed;
        t_pixel_res want;
    } t_script_row;

    // A result passes stage 1, stage 2 and the output register before it leaves, so
    // SETTLE_CYCLES of quiet are enough to be sure that nothing is still in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1350;

    // Oversized frame: the first pixels of row 0 go in under the clamped size, then a
    // narrower width ends the row and the frame.
    localparam int OVERSIZE_HEAD = 40;
    localparam int OVERSIZE_COLS = 48;

    // Directed frame of 3 x 3 pixels. Unselected pixels pass straight through one row
    // later, so their results are typed in; selected ones go through the predictor.
    localparam int SCRIPT_LEN = 14;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // Row 0 fills the line stores and yields nothing.
        '{ACT_PIXEL, 24'hFF00FF, 1'b0, 1'b0, '0},
        '{ACT_PIXEL, 24'h00FF00, 1'b1, 1'b0, '0},
        '{ACT_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, '0},
        // Row 1 emits row 0.
        '{ACT_PIXEL, 24'h000000, 1'b1, 1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b0}},
        '{ACT_PIXEL, 24'h808080, 1'b0, 1'b0, '0},
        '{ACT_PIXEL, 24'h010203, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        // Row 2 emits row 1; its last pixel completes the frame.
        '{ACT_PIXEL, 24'h102030, 1'b0, 1'b0, '0},
        '{ACT_PIXEL, 24'hFFFFFF, 1'b1, 1'b1, '{8'h80, 8'h80, 8'h80, 1'b0}},
        '{ACT_PIXEL, 24'h000000, 1'b0, 1'b0, '0},
        // A pixel that arrives while the last row waits is dropped.
        '{ACT_PIXEL, 24'h7F7F7F, 1'b1, 1'b0, '0},
        // Drains flush row 2; the last one marks the end of the frame.
        '{ACT_DRAIN, 24'h000000, 1'b0, 1'b1, '{8'h10, 8'h20, 8'h30, 1'b0}},
        '{ACT_DRAIN, 24'hFFFFFF, 1'b1, 1'b0, '0},
        '{ACT_DRAIN, 24'h000000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        // Nothing is left to flush, so this drain yields nothing.
        '{ACT_DRAIN, 24'hFFFFFF, 1'b1, 1'b0, '0}
    };

    // Frame sizes at the low end of the registers. Zero values are clamped by the
    // block; the width register keeps only its low 12 bits.
    localparam int NUM_LIMIT_SIZES = 4;
    localparam logic [CFG_DATA_W-1:0] LIMIT_COLS [NUM_LIMIT_SIZES] =
        '{13'd0, 13'h1005, 13'd2, 13'd1};
    localparam logic [CFG_DATA_W-1:0] LIMIT_ROWS [NUM_LIMIT_SIZES] =
        '{13'd0, 13'd2, 13'd0, 13'd6};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pwmf_in_if  pix_ch ();
    pwmf_out_if res_ch ();

    plus_window_rgb_median_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch.sink),
        .o_res       (res_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor state: the two line stores, the raster position of the next pixel,
    // the flush position of the last row and the frame size registers.
    t_rgb              upper_line  [MAX_WIDTH];
    t_mid              middle_line [MAX_WIDTH];
    int                col_pos;
    int                row_pos;
    int                flush_pos;
    bit                flushing;
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;

    t_pixel_res expected_pixels [$];
    int         mismatches = 0;
    int         quiet_cycles;
    int         frame_items;
    int         tx_gap_max;
    int         rx_stall_max;

    // Typed results of the directed script travel with the item, so they are
    // driven like the payload and sampled at the same edge.
    bit         typed_flag;
    t_pixel_res typed_pixel;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int frame_cols();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int frame_rows();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // Middle value of n samples; for an even count the truncated mean of the two
    // middle values.
    function automatic t_chan median_of_window(input t_chan v [WIN_N], input int n);
        t_chan key;
        int    j;
        for (int i = 1; i < n; i++) begin
            key = v[i];
            j = i;
            while (j > 0 && v[j-1] > key) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = key;
        end
        if (n % 2 == 1) return v[n/2];
        return t_chan'((int'(v[n/2-1]) + int'(v[n/2])) / 2);
    endfunction

    // Produces the output row pixel at column x from its plus-shaped window, then
    // moves that pixel into the row-above store. Entries of the row-above store left
    // of x already hold the output row, which makes them the left neighbors.
    task automatic filter_line_pixel(input int x, input bit have_up, input bit have_down,
                                     input t_rgb down_rgb, output t_pixel_res res);
        t_mid  centre;
        t_rgb  win [WIN_N];
        t_chan vals [WIN_N];
        t_rgb  out_rgb;
        int    n;
        centre = middle_line[x];
        win[0] = centre.rgb;
        n = 1;
        if (x + 1 < frame_cols()) begin
            win[n] = middle_line[x+1].rgb;
            n++;
        end
        if (x >= 1) begin
            win[n] = upper_line[x-1];
            n++;
        end
        if (have_down) begin
            win[n] = down_rgb;
            n++;
        end
        if (have_up) begin
            win[n] = upper_line[x];
            n++;
        end
        out_rgb = centre.rgb;
        if (centre.sel) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                for (int k = 0; k < WIN_N; k++) vals[k] = win[k][CH_W*ch +: CH_W];
                out_rgb[CH_W*ch +: CH_W] = median_of_window(vals, n);
            end
        end
        res.red       = out_rgb[2*CH_W +: CH_W];
        res.green     = out_rgb[CH_W +: CH_W];
        res.blue      = out_rgb[0 +: CH_W];
        res.frame_end = 1'b0;
        upper_line[x] = centre.rgb;
    endtask

    // Advances the predictor by one accepted item and tells whether it yields a pixel.
    task automatic next_filtered_pixel(input t_action act, input t_rgb rgb, input logic sel,
                                       output bit has_res, output t_pixel_res res);
        int cols;
        int rows;
        int x;
        int y;
        cols = frame_cols();
        rows = frame_rows();
        has_res = 1'b0;
        res = '0;
        if (act == ACT_DRAIN) begin
            if (flushing) begin
                x = flush_pos;
                filter_line_pixel(x, rows >= 2, 1'b0, '0, res);
                has_res = 1'b1;
                if (x + 1 >= cols) begin
                    res.frame_end = 1'b1;
                    flushing = 1'b0;
                    flush_pos = 0;
                end else begin
                    flush_pos = x + 1;
                end
            end
        end else if (!flushing) begin
            x = col_pos;
            y = row_pos;
            if (y >= 1) begin
                filter_line_pixel(x, y >= 2, 1'b1, rgb, res);
                has_res = 1'b1;
            end else begin
                upper_line[x] = middle_line[x].rgb;
            end
            middle_line[x] = {sel, rgb};
            if (x + 1 >= cols) begin
                col_pos = 0;
                if (y + 1 >= rows) begin
                    row_pos = 0;
                    flushing = 1'b1;
                    flush_pos = 0;
                end else begin
                    row_pos = y + 1;
                end
            end else begin
                col_pos = x + 1;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Scoreboard. Everything is sampled at the rising edge, before the edge's own
    // updates land, so both sides see exactly what was handed over. Register writes
    // are tracked here from the configuration port.
    always @(posedge i_clk) begin
        bit         has_res;
        t_pixel_res want;
        t_pixel_res got;
        if (!i_rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            flush_pos  = 0;
            flushing   = 1'b0;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (middle_line[i]) middle_line[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_wdata[WREG_W-1:0];
                end else begin
                    height_reg = i_cfg_wdata[HREG_W-1:0];
                end
            end
            if (pix_ch.valid && pix_ch.ready) begin
                next_filtered_pixel(t_action'(pix_ch.action),
                                    {pix_ch.red_in, pix_ch.green_in, pix_ch.blue_in},
                                    pix_ch.selected, has_res, want);
                if (has_res) expected_pixels.push_back(typed_flag ? typed_pixel : want);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.red_out, res_ch.green_out, res_ch.blue_out, res_ch.frame_end};
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result pixel %0h %0h %0h frame_end %0b",
                           got.red, got.green, got.blue, got.frame_end);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_out", want.red, got.red);
                    check_field("green_out", want.green, got.green);
                    check_field("blue_out", want.blue, got.blue);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
        end
    end

    // The run is stuck if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_ch.valid && pix_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: before each result it takes, the receiver may hold ready low for a
    // random stall.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Hands one item to the block after a random gap and returns at the edge that
    // takes it. A valid that stays high from one item to the next is never dropped.
    task automatic send_item(input t_action act, input t_rgb rgb, input logic sel,
                             input bit typed, input t_pixel_res want);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.action   <= act;
        pix_ch.red_in   <= rgb[2*CH_W +: CH_W];
        pix_ch.green_in <= rgb[CH_W +: CH_W];
        pix_ch.blue_in  <= rgb[0 +: CH_W];
        pix_ch.selected <= sel;
        typed_flag      <= typed;
        typed_pixel     <= want;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
    endtask

    // Stops sending and waits until every expected pixel has come out.
    task automatic hold_until_drained();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    // Frame size changes only with the pipeline empty. A closing wait after the writes lets
    // the scoreboard take the new size before anyone reads it.
    task automatic set_frame_size(input logic [CFG_DATA_W-1:0] cols_word,
                                  input logic [CFG_DATA_W-1:0] rows_word);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_IMAGE_WIDTH;
        i_cfg_wdata <= cols_word;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_IMAGE_HEIGHT;
        i_cfg_wdata <= rows_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_rgb random_rgb(input t_chan mask);
        return t_rgb'($urandom()) & {NUM_CH{mask}};
    endfunction

    // Sends one whole frame with random content followed by the drains that flush
    // its last row. Stray drains during the pixels and stray pixels during the flush
    // are mixed in; the block has to ignore them. A narrow value range now and then
    // makes ties and equal neighbors common in the medians.
    task automatic run_frame(input int pause_at);
        int    cols;
        int    area;
        t_chan mask;
        cols = frame_cols();
        area = cols * frame_rows();
        mask = ($urandom_range(0, 3) == 0) ? 8'h03 : 8'hFF;
        if (area > 300) begin
            tx_gap_max   = 2;
            rx_stall_max = 2;
        end else begin
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        end
        for (int i = 0; i < area; i++) begin
            if (i == pause_at) hold_until_drained();
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_DRAIN, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);
            send_item(ACT_PIXEL, random_rgb(mask), 1'($urandom()), 1'b0, '0);
            frame_items++;
        end
        for (int i = 0; i < cols; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_PIXEL, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);
            send_item(ACT_DRAIN, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);
            frame_items++;
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cols_word;
        logic [CFG_DATA_W-1:0] rows_word;
        frame_items     = 0;
        tx_gap_max      = 12;
        rx_stall_max    = 12;
        typed_flag      = 1'b0;
        typed_pixel     = '0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_IMAGE_WIDTH;
        i_cfg_wdata     = '0;
        pix_ch.valid    = 1'b0;
        pix_ch.action   = ACT_PIXEL;
        pix_ch.red_in   = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in  = '0;
        pix_ch.selected = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Right after reset nothing waits to be flushed, so a drain yields nothing.
        send_item(ACT_DRAIN, 24'hFFFFFF, 1'b1, 1'b0, '0);

        // Directed frame of 3 x 3 pixels.
        set_frame_size(13'd3, 13'd3);
        foreach (SCRIPT[i])
            send_item(SCRIPT[i].act, SCRIPT[i].rgb, SCRIPT[i].sel, SCRIPT[i].typed,
                      SCRIPT[i].want);

        // Oversized registers clamp to the largest frame, so the first pixels stay in
        // row 0. A narrower width written part way through then ends the only row.
        set_frame_size(13'd4095, 13'd8191);
        for (int i = 0; i < OVERSIZE_HEAD; i++)
            send_item(ACT_PIXEL, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);
        set_frame_size(13'(OVERSIZE_COLS), 13'd1);
        for (int i = OVERSIZE_HEAD; i < OVERSIZE_COLS; i++)
            send_item(ACT_PIXEL, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);
        for (int i = 0; i < OVERSIZE_COLS; i++)
            send_item(ACT_DRAIN, random_rgb(8'hFF), 1'($urandom()), 1'b0, '0);

        // Frames at the low end of the registers: single pixel, a masked width write,
        // a single row and a single column.
        for (int i = 0; i < NUM_LIMIT_SIZES; i++) begin
            set_frame_size(LIMIT_COLS[i], LIMIT_ROWS[i]);
            run_frame(-1);
        end

        // Random small frames. Most change the size, some repeat the last one.
        frame_items = 0;
        while (frame_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                cols_word = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 96)
                                                        : $urandom_range(1, 12);
                rows_word = $urandom_range(1, 8);
                set_frame_size(cols_word, rows_word);
            end
            run_frame(($urandom_range(0, 7) == 0) ? frame_cols() : -1);
        end

        hold_until_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
